// ===== sv/crc_pkg.sv =====
// Shared types and constants for the Catmull-Rom curve point unit.
// Depends on nothing; used by the top level and the axis datapath.
`timescale 1ns / 1ps
package crc_pkg;

    // Default sizes handed to the top level
    localparam int MAX_POINTS_DEF  = 64;
    localparam int T_FRAC_BITS_DEF = 16;

    // Field widths fixed by the port list
    localparam int COORD_W = 32;
    localparam int LOCK_W  = 3;
    localparam int ENTRY_W = 3 * COORD_W + LOCK_W;
    localparam int COUNT_W = 7;

    // Internal coefficient width: holds 12 * 2^31 with margin
    localparam int COEF_W = 40;

    // Request codes
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_EVAL  = 1'b1;

    // Register indexes
    localparam logic CFG_POINT_COUNT = 1'b0;
    localparam logic CFG_CLOSED_LOOP = 1'b1;

    // Four neighbouring points of one axis plus the linear-mode flag
    typedef struct packed {
        logic signed [COORD_W-1:0] p0;
        logic signed [COORD_W-1:0] p1;
        logic signed [COORD_W-1:0] p2;
        logic signed [COORD_W-1:0] p3;
        logic                      lin;
    } axis_in_t;

endpackage

// ===== sv/crc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
module crc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write one entry, register the read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/crc_axis.sv =====
// Seven-stage datapath for one axis: coefficients, Horner chain, saturation.
// Depends on crc_pkg.
`timescale 1ns / 1ps
module crc_axis #(
    parameter int T_FRAC_BITS = crc_pkg::T_FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  crc_pkg::axis_in_t                  pts,
    input  logic [T_FRAC_BITS:0]               t_val,
    output logic signed [crc_pkg::COORD_W-1:0] value
);

    localparam int CW = crc_pkg::COEF_W;
    localparam int TW = T_FRAC_BITS + 2;
    localparam int PW = CW + TW;
    localparam logic signed [PW-1:0] HALF = PW'(1) <<< (T_FRAC_BITS - 1);
    localparam logic signed [CW-1:0] SAT_MAX = CW'((64'sd1 <<< 31) - 64'sd1);
    localparam logic signed [CW-1:0] SAT_MIN = -(CW'(64'sd1 <<< 31));

    function automatic logic signed [CW-1:0] sx(input logic signed [31:0] v);
        return CW'(v);
    endfunction

    // Stage 1: coefficients
    logic signed [CW-1:0] b1_reg, c1_reg, d1_reg, p1_1_reg;
    logic signed [CW-1:0] b1_next, c1_next, d1_next;
    logic                 lin1_reg;
    logic signed [TW-1:0] t1_reg;

    always_comb
    begin
        if (pts.lin)
        begin
            b1_next = sx(pts.p2) - sx(pts.p1);
            c1_next = '0;
            d1_next = '0;
        end
        else
        begin
            b1_next = sx(pts.p2) - sx(pts.p0);
            c1_next = (sx(pts.p0) <<< 1) - (sx(pts.p1) <<< 2) - sx(pts.p1)
                      + (sx(pts.p2) <<< 2) - sx(pts.p3);
            d1_next = (sx(pts.p1) <<< 1) + sx(pts.p1) - sx(pts.p0)
                      - (sx(pts.p2) <<< 1) - sx(pts.p2) + sx(pts.p3);
        end
    end

    always_ff @(posedge clk)
    begin
        b1_reg   <= b1_next;
        c1_reg   <= c1_next;
        d1_reg   <= d1_next;
        p1_1_reg <= sx(pts.p1);
        lin1_reg <= pts.lin;
        t1_reg   <= signed'({1'b0, t_val});
    end

    // Stage 2: d * t
    logic signed [PW-1:0] m2_reg;
    logic signed [CW-1:0] b2_reg, c2_reg, p1_2_reg;
    logic                 lin2_reg;
    logic signed [TW-1:0] t2_reg;

    always_ff @(posedge clk)
    begin
        m2_reg   <= d1_reg * t1_reg;
        b2_reg   <= b1_reg;
        c2_reg   <= c1_reg;
        p1_2_reg <= p1_1_reg;
        lin2_reg <= lin1_reg;
        t2_reg   <= t1_reg;
    end

    // Stage 3: round and add c
    logic signed [PW-1:0] r3_sum;
    logic signed [CW-1:0] h3_reg, b3_reg, p1_3_reg;
    logic                 lin3_reg;
    logic signed [TW-1:0] t3_reg;

    assign r3_sum = m2_reg + HALF;

    always_ff @(posedge clk)
    begin
        h3_reg   <= CW'(r3_sum >>> T_FRAC_BITS) + c2_reg;
        b3_reg   <= b2_reg;
        p1_3_reg <= p1_2_reg;
        lin3_reg <= lin2_reg;
        t3_reg   <= t2_reg;
    end

    // Stage 4: multiply by t
    logic signed [PW-1:0] m4_reg;
    logic signed [CW-1:0] b4_reg, p1_4_reg;
    logic                 lin4_reg;
    logic signed [TW-1:0] t4_reg;

    always_ff @(posedge clk)
    begin
        m4_reg   <= h3_reg * t3_reg;
        b4_reg   <= b3_reg;
        p1_4_reg <= p1_3_reg;
        lin4_reg <= lin3_reg;
        t4_reg   <= t3_reg;
    end

    // Stage 5: round and add b
    logic signed [PW-1:0] r5_sum;
    logic signed [CW-1:0] h5_reg, p1_5_reg;
    logic                 lin5_reg;
    logic signed [TW-1:0] t5_reg;

    assign r5_sum = m4_reg + HALF;

    always_ff @(posedge clk)
    begin
        h5_reg   <= CW'(r5_sum >>> T_FRAC_BITS) + b4_reg;
        p1_5_reg <= p1_4_reg;
        lin5_reg <= lin4_reg;
        t5_reg   <= t4_reg;
    end

    // Stage 6: multiply by t
    logic signed [PW-1:0] m6_reg;
    logic signed [CW-1:0] p1_6_reg;
    logic                 lin6_reg;

    always_ff @(posedge clk)
    begin
        m6_reg   <= h5_reg * t5_reg;
        p1_6_reg <= p1_5_reg;
        lin6_reg <= lin5_reg;
    end

    // Stage 7: round, add constant term, saturate
    logic signed [PW-1:0] r7_sum;
    logic signed [CW-1:0] h7, half_sum, fin;
    logic signed [crc_pkg::COORD_W-1:0] value_reg, value_next;

    assign r7_sum = m6_reg + HALF;

    always_comb
    begin
        h7       = CW'(r7_sum >>> T_FRAC_BITS);
        half_sum = h7 + (p1_6_reg <<< 1) + CW'(1);
        fin      = lin6_reg ? (h7 + p1_6_reg) : (half_sum >>> 1);
        if (fin > SAT_MAX)
        begin
            value_next = crc_pkg::COORD_W'(SAT_MAX);
        end
        else if (fin < SAT_MIN)
        begin
            value_next = crc_pkg::COORD_W'(SAT_MIN);
        end
        else
        begin
            value_next = crc_pkg::COORD_W'(fin);
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

// ===== sv/catmull_rom_curve_point_top.sv =====
// Uniform Catmull-Rom curve point unit: point table, neighbour lookup, three axis pipes.
// Depends on crc_pkg, crc_ram and crc_axis.
// Throughput: one item per cycle; busy stays low.
// The rate is set by the four replicated point-table RAMs, one read port per neighbour.
// Reset clears valid bits and sets point_count to 2, closed_loop to 0; the table is
// undefined until written. The receiver cannot stall, so results are never held.
`timescale 1ns / 1ps
module catmull_rom_curve_point_top #(
    parameter int MAX_POINTS  = crc_pkg::MAX_POINTS_DEF,
    parameter int T_FRAC_BITS = crc_pkg::T_FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               cfg_we,
    input  logic                               cfg_index,
    input  logic [crc_pkg::COUNT_W-1:0]        cfg_data,
    input  logic                               req_type,
    input  logic [5:0]                         point_index,
    input  logic signed [31:0]                 pos_x,
    input  logic signed [31:0]                 pos_y,
    input  logic signed [31:0]                 pos_z,
    input  logic [2:0]                         lock_bits,
    input  logic [5:0]                         segment,
    input  logic [T_FRAC_BITS:0]               t_frac,
    output logic                               done,
    output logic signed [31:0]                 out_x,
    output logic signed [31:0]                 out_y,
    output logic signed [31:0]                 out_z,
    output logic                               segment_error
);

    localparam int AW     = $clog2(MAX_POINTS);
    localparam int CNW    = crc_pkg::COUNT_W;
    localparam int STAGES = 8;
    localparam logic [T_FRAC_BITS:0] T_ONE = (T_FRAC_BITS + 1)'(1) << T_FRAC_BITS;

    // Configuration registers
    logic [CNW-1:0] point_count_reg;
    logic           closed_loop_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg <= CNW'(2);
            closed_loop_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                crc_pkg::CFG_POINT_COUNT: point_count_reg <= cfg_data;
                crc_pkg::CFG_CLOSED_LOOP: closed_loop_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    // Neighbour index: wrap when closed, clamp when open
    function automatic logic [10:0] nb(input logic signed [10:0] i,
                                       input logic [CNW-1:0] n,
                                       input logic closed);
        logic signed [10:0] r;
        logic signed [10:0] ns;
        ns = signed'({4'b0, n});
        r  = i;
        if (closed)
        begin
            if (r < 11'sd0) r = r + ns;
            if (r >= ns)    r = r - ns;
        end
        else
        begin
            if (r < 11'sd0)           r = 11'sd0;
            if (r > ns - 11'sd1)      r = ns - 11'sd1;
        end
        return unsigned'(r);
    endfunction

    // Accept stage: clamp count, segment and fraction, form addresses
    logic                 accept, eval_acc, wr_acc;
    logic [CNW-1:0]       n_eff, last_seg, seg_cl;
    logic                 seg_err;
    logic [T_FRAC_BITS:0] t_cl;
    logic signed [10:0]   base;
    logic [10:0]          idx [4];
    logic [10:0]          widx;
    logic [AW-1:0]        raddr [4];

    assign accept   = start && !busy;
    assign eval_acc = accept && (req_type == crc_pkg::REQ_EVAL);
    assign widx     = 11'(point_index);
    assign wr_acc   = accept && (req_type == crc_pkg::REQ_WRITE)
                      && (32'(point_index) < MAX_POINTS);

    always_comb
    begin
        if (point_count_reg < CNW'(2))
        begin
            n_eff = CNW'(2);
        end
        else if (32'(point_count_reg) > MAX_POINTS)
        begin
            n_eff = CNW'(MAX_POINTS);
        end
        else
        begin
            n_eff = point_count_reg;
        end
        last_seg = closed_loop_reg ? (n_eff - CNW'(1)) : (n_eff - CNW'(2));
        if ({1'b0, segment} > last_seg)
        begin
            seg_cl  = last_seg;
            seg_err = 1'b1;
        end
        else
        begin
            seg_cl  = {1'b0, segment};
            seg_err = 1'b0;
        end
        t_cl   = (t_frac > T_ONE) ? T_ONE : t_frac;
        base   = signed'({4'b0, seg_cl}) - 11'sd1;
        idx[0] = nb(base,          n_eff, closed_loop_reg);
        idx[1] = nb(base + 11'sd1, n_eff, closed_loop_reg);
        idx[2] = nb(base + 11'sd2, n_eff, closed_loop_reg);
        idx[3] = nb(base + 11'sd3, n_eff, closed_loop_reg);
        for (int k = 0; k < 4; k++)
        begin
            raddr[k] = idx[k][AW-1:0];
        end
    end

    // Point table: one copy per neighbour tap, all written together
    logic [crc_pkg::ENTRY_W-1:0] wentry;
    logic [crc_pkg::ENTRY_W-1:0] rentry [4];

    assign wentry = {lock_bits, pos_z, pos_y, pos_x};

    for (genvar g = 0; g < 4; g++)
    begin : g_tap
        crc_ram #(
            .WIDTH (crc_pkg::ENTRY_W),
            .DEPTH (MAX_POINTS)
        ) u_ram (
            .clk   (clk),
            .we    (wr_acc),
            .waddr (widx[AW-1:0]),
            .wdata (wentry),
            .raddr (raddr[g]),
            .rdata (rentry[g])
        );
    end

    // Valid and error bits travel with the data
    logic [STAGES-1:0] vld_reg, err_reg;
    logic [T_FRAC_BITS:0] t1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            err_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[STAGES-2:0], eval_acc};
            err_reg <= {err_reg[STAGES-2:0], eval_acc && seg_err};
        end
    end

    always_ff @(posedge clk)
    begin
        t1_reg <= t_cl;
    end

    // Unpack neighbours and decide linear axes
    logic [2:0]        locks;
    crc_pkg::axis_in_t ax_in [3];

    assign locks = rentry[1][crc_pkg::ENTRY_W-1 -: 3] & rentry[2][crc_pkg::ENTRY_W-1 -: 3];

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            ax_in[a].p0 = rentry[0][a*32 +: 32];
            ax_in[a].p1 = rentry[1][a*32 +: 32];
            ax_in[a].p2 = rentry[2][a*32 +: 32];
            ax_in[a].p3 = rentry[3][a*32 +: 32];
        end
        ax_in[0].lin = |(locks & 3'b011);
        ax_in[1].lin = |(locks & 3'b101);
        ax_in[2].lin = |(locks & 3'b110);
    end

    crc_axis #(.T_FRAC_BITS(T_FRAC_BITS)) u_axis_x
        (.clk(clk), .pts(ax_in[0]), .t_val(t1_reg), .value(out_x));
    crc_axis #(.T_FRAC_BITS(T_FRAC_BITS)) u_axis_y
        (.clk(clk), .pts(ax_in[1]), .t_val(t1_reg), .value(out_y));
    crc_axis #(.T_FRAC_BITS(T_FRAC_BITS)) u_axis_z
        (.clk(clk), .pts(ax_in[2]), .t_val(t1_reg), .value(out_z));

    assign done          = vld_reg[STAGES-1];
    assign segment_error = err_reg[STAGES-1];

    // Checks
    a_vld_from_eval: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[0] |-> $past(start && req_type == crc_pkg::REQ_EVAL))
        else $error("pipeline entry without an evaluate beat");

    a_err_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        segment_error |-> done)
        else $error("segment error outside a result beat");

    a_write_no_entry: assert property (@(posedge clk) disable iff (!rst_n)
        wr_acc |=> !vld_reg[0])
        else $error("write beat entered the evaluate pipeline");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        n_eff >= CNW'(2) && 32'(n_eff) <= MAX_POINTS)
        else $error("effective point count out of range");

endmodule
